FILE: rtl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg: shared definitions of the palette fade engine
// Item codes, sweep operations, default sizes and the payload structs of the
// input and result channels.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // Default palette size and component width.
  localparam int unsigned EntryCountDefault    = 256;
  localparam int unsigned ComponentBitsDefault = 8;

  // Item codes carried in the kind field.
  localparam logic [2:0] KindWrite   = 3'd0;
  localparam logic [2:0] KindFadeOut = 3'd1;
  localparam logic [2:0] KindFadeIn  = 3'd2;
  localparam logic [2:0] KindTick    = 3'd3;
  localparam logic [2:0] KindRead    = 3'd4;

  // Operation that the step unit applies to each entry during a sweep.
  typedef enum logic [1:0] {
    OP_CHECK,
    OP_FADE_OUT,
    OP_FADE_IN,
    OP_TICK
  } sweep_op_e;

  // One input item.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] entry_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pfe_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       fade_done;
  } pfe_out_t;

endpackage

FILE: rtl/pfe_step_unit.sv
// ----------------------------------------------------------------------------
// pfe_step_unit: per-entry update and compare unit
// Computes the new value of the three components of one palette entry for
// the current sweep operation and flags whether any of them misses its goal.
// ----------------------------------------------------------------------------
module pfe_step_unit #(
  parameter int unsigned CompBits = pfe_pkg::ComponentBitsDefault
) (
  input  logic [2:0][CompBits-1:0] cur_i,
  input  logic [2:0][CompBits-1:0] tgt_i,
  input  pfe_pkg::sweep_op_e       op_i,
  input  logic                     fading_in_i,
  output logic [2:0][CompBits-1:0] nxt_o,
  output logic                     mismatch_o
);

  logic [2:0][CompBits-1:0] goal;

  // The goal is the target while fading in and black otherwise; each lane
  // takes its new value and is compared against that goal.
  always_comb begin
    mismatch_o = 1'b0;
    for (int c = 0; c < 3; c++) begin
      goal[c] = fading_in_i ? tgt_i[c] : '0;
      case (op_i)
        pfe_pkg::OP_FADE_OUT: nxt_o[c] = tgt_i[c];
        pfe_pkg::OP_FADE_IN:  nxt_o[c] = '0;
        pfe_pkg::OP_TICK: begin
          if (cur_i[c] < goal[c]) begin
            nxt_o[c] = cur_i[c] + CompBits'(1);
          end else if (cur_i[c] > goal[c]) begin
            nxt_o[c] = cur_i[c] - CompBits'(1);
          end else begin
            nxt_o[c] = cur_i[c];
          end
        end
        default: nxt_o[c] = cur_i[c];
      endcase
      mismatch_o = mismatch_o | (nxt_o[c] != goal[c]);
    end
  end

endmodule

FILE: rtl/palette_fade_engine.sv
// ----------------------------------------------------------------------------
// palette_fade_engine: palette fade engine, top level
// Target and current palettes in two memories, a small sequencer and one
// shared step unit that walks the palette one entry per cycle.
// ----------------------------------------------------------------------------
// Every accepted item gives one result. Fade-out, fade-in and tick items walk
// the whole palette through the step unit, one entry per cycle over the
// single read port of each memory. A target write rechecks the done flag over
// every entry while fading in and not while the goal is black. After reset
// the block clears both memories entry by entry and does not accept items
// during that pass. fade_done reports whether every component of the current
// palette equals its goal after the item.
module palette_fade_engine #(
  parameter int unsigned ENTRY_COUNT    = pfe_pkg::EntryCountDefault,
  parameter int unsigned COMPONENT_BITS = pfe_pkg::ComponentBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pfe_pkg::pfe_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pfe_pkg::pfe_out_t out_data_o
);

  localparam int unsigned AddrBits = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam logic [AddrBits-1:0] LastAddr = AddrBits'(ENTRY_COUNT - 1);

  typedef logic [2:0][COMPONENT_BITS-1:0] color_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_READ,
    S_RDATA,
    S_SWEEP,
    S_DRAIN,
    S_FINISH
  } state_e;

  // Palette memories and their registered read data.
  color_t target_mem  [ENTRY_COUNT];
  color_t current_mem [ENTRY_COUNT];
  color_t tgt_rd_q;
  color_t cur_rd_q;

  // Sequencer and result registers.
  state_e             state_q;
  pfe_pkg::pfe_in_t   item_q;
  pfe_pkg::sweep_op_e op_q;
  logic [AddrBits-1:0] addr_q;
  logic [AddrBits-1:0] rd_addr_q;
  logic               rd_vld_q;
  logic               mism_q;
  logic               matched_q;
  logic               fading_in_q;
  logic [2:0][7:0]    res_color_q;
  logic               out_valid_q;
  pfe_pkg::pfe_out_t  out_data_q;

  // Memory port signals.
  logic                item_in_range;
  logic [AddrBits-1:0] item_addr;
  logic [AddrBits-1:0] cur_raddr;
  logic                tgt_we;
  logic [AddrBits-1:0] tgt_waddr;
  color_t              tgt_wdata;
  logic                cur_we;
  logic [AddrBits-1:0] cur_waddr;
  color_t              cur_wdata;

  // Step unit results.
  color_t step_nxt;
  logic   step_mismatch;

  // Addressing of the item held in the sequencer.
  assign item_in_range = 32'(item_q.entry_index) < ENTRY_COUNT;
  assign item_addr     = AddrBits'(item_q.entry_index);
  assign cur_raddr     = (state_q == S_READ) ? item_addr : addr_q;

  // Write ports: the clearing pass zeroes both memories, a target write
  // stores the masked components, and a sweep writes back the step result.
  always_comb begin
    tgt_we    = 1'b0;
    tgt_waddr = addr_q;
    tgt_wdata = '0;
    cur_we    = 1'b0;
    cur_waddr = addr_q;
    cur_wdata = '0;
    if (state_q == S_CLEAR) begin
      tgt_we = 1'b1;
      cur_we = 1'b1;
    end
    if (state_q == S_WRITE && item_in_range) begin
      tgt_we       = 1'b1;
      tgt_waddr    = item_addr;
      tgt_wdata[0] = COMPONENT_BITS'(item_q.red_in);
      tgt_wdata[1] = COMPONENT_BITS'(item_q.green_in);
      tgt_wdata[2] = COMPONENT_BITS'(item_q.blue_in);
    end
    if (rd_vld_q) begin
      cur_we    = 1'b1;
      cur_waddr = rd_addr_q;
      cur_wdata = step_nxt;
    end
  end

  // Memories with one write and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (tgt_we) begin
      target_mem[tgt_waddr] <= tgt_wdata;
    end
    if (cur_we) begin
      current_mem[cur_waddr] <= cur_wdata;
    end
    tgt_rd_q <= target_mem[addr_q];
    cur_rd_q <= current_mem[cur_raddr];
  end

  // Shared step unit, fed with one entry per cycle during a sweep.
  pfe_step_unit #(
    .CompBits (COMPONENT_BITS)
  ) u_step (
    .cur_i       (cur_rd_q),
    .tgt_i       (tgt_rd_q),
    .op_i        (op_q),
    .fading_in_i (fading_in_q),
    .nxt_o       (step_nxt),
    .mismatch_o  (step_mismatch)
  );

  // Sequencer: clearing pass, item decode, sweeps, reads and result output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      item_q      <= '0;
      op_q        <= pfe_pkg::OP_CHECK;
      addr_q      <= '0;
      rd_addr_q   <= '0;
      rd_vld_q    <= 1'b0;
      mism_q      <= 1'b0;
      matched_q   <= 1'b1;
      fading_in_q <= 1'b0;
      res_color_q <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= 1'b0;
      if (rd_vld_q) begin
        mism_q <= mism_q | step_mismatch;
      end
      case (state_q)
        S_CLEAR: begin
          addr_q <= AddrBits'(addr_q + 1'b1);
          if (addr_q == LastAddr) begin
            addr_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            item_q      <= in_data_i;
            addr_q      <= '0;
            mism_q      <= 1'b0;
            res_color_q <= '0;
            case (in_data_i.kind)
              pfe_pkg::KindWrite: state_q <= S_WRITE;
              pfe_pkg::KindFadeOut: begin
                fading_in_q <= 1'b0;
                op_q        <= pfe_pkg::OP_FADE_OUT;
                state_q     <= S_SWEEP;
              end
              pfe_pkg::KindFadeIn: begin
                fading_in_q <= 1'b1;
                op_q        <= pfe_pkg::OP_FADE_IN;
                state_q     <= S_SWEEP;
              end
              pfe_pkg::KindTick: begin
                op_q    <= pfe_pkg::OP_TICK;
                state_q <= S_SWEEP;
              end
              pfe_pkg::KindRead: state_q <= S_READ;
              default:           state_q <= S_FINISH;
            endcase
          end
        end
        S_WRITE: begin
          // A new target only moves the goal while fading in.
          op_q    <= pfe_pkg::OP_CHECK;
          state_q <= fading_in_q ? S_SWEEP : S_FINISH;
        end
        S_READ: begin
          state_q <= S_RDATA;
        end
        S_RDATA: begin
          if (item_in_range) begin
            res_color_q[0] <= 8'(cur_rd_q[0]);
            res_color_q[1] <= 8'(cur_rd_q[1]);
            res_color_q[2] <= 8'(cur_rd_q[2]);
          end
          state_q <= S_FINISH;
        end
        S_SWEEP: begin
          rd_vld_q  <= 1'b1;
          rd_addr_q <= addr_q;
          addr_q    <= AddrBits'(addr_q + 1'b1);
          if (addr_q == LastAddr) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // The last entry is in the step unit during this cycle.
          matched_q <= !(mism_q | step_mismatch);
          state_q   <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q          <= 1'b1;
            out_data_q.red_out   <= res_color_q[0];
            out_data_q.green_out <= res_color_q[1];
            out_data_q.blue_out  <= res_color_q[2];
            out_data_q.fade_done <= matched_q;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker: port-level checks of the palette fade engine
// Watches the handshakes of the top level and the count of items in flight.
// ----------------------------------------------------------------------------
module pfe_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pfe_pkg::pfe_out_t out_data_o
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Items accepted whose result has not yet been transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else begin
      pending_q <= 2'(pending_q + {1'b0, in_xfer} - {1'b0, out_xfer});
    end
  end

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // The engine takes one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input ready right after an item transfer");

  // The clearing pass after reset holds off input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input ready during the clearing pass");

  // No result without an item behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result offered with no item in flight");

  // At most one item in work and one result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many items in flight");

endmodule

bind palette_fade_engine pfe_checker u_pfe_checker (.*);

FILE: tb/sv/palette_fade_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palette_fade_engine_test: self-checking testbench of the palette fade engine
// A short table of directed items covers the reset state, the extremes of the
// fields, every item kind and the corner cases of the fade. Random scenes
// follow: target writes, a fade start, enough ticks to finish or cut a fade,
// reads along the way, with noise items mixed in. A predictor of both palettes
// gives each result the table leaves open; both channels idle at random.
// ----------------------------------------------------------------------------
module palette_fade_engine_test;
  import pfe_pkg::*;

  localparam int unsigned Entries      = EntryCountDefault;
  localparam int unsigned ItemGoal     = 1400;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned SettleCycles = Entries + 40;
  localparam int unsigned ShortFade    = 40;
  localparam int unsigned LowLevel     = 15;

  // Kinds that the block leaves without effect.
  localparam logic [2:0] KindSpareLow  = 3'd5;
  localparam logic [2:0] KindSpareMid  = 3'd6;
  localparam logic [2:0] KindSpareHigh = 3'd7;

  // Results whose value is plain after reset and at the fade extremes.
  localparam pfe_out_t BlankDone = '{8'h00, 8'h00, 8'h00, 1'b1};
  localparam pfe_out_t BlankBusy = '{8'h00, 8'h00, 8'h00, 1'b0};

  typedef struct {
    pfe_in_t  item;
    bit       typed;
    pfe_out_t result;
  } dir_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  pfe_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  pfe_out_t out_data_o;

  // Predicted palettes and fade direction.
  logic [7:0] target_pal [Entries][3];
  logic [7:0] shown_pal  [Entries][3];
  logic       fading_in_q;

  // Results still to come, oldest first.
  pfe_out_t   pending_results[$];
  logic [7:0] touched[$];
  dir_row_t   dir_rows[$];

  int unsigned mismatches   = 0;
  int unsigned reported     = 0;
  int unsigned items_sent   = 0;
  int unsigned items_real   = 0;
  int unsigned ticks_sent   = 0;
  int unsigned fades_sent   = 0;
  int unsigned reads_sent   = 0;
  int unsigned writes_sent  = 0;
  int unsigned spare_sent   = 0;
  int unsigned settled_seen = 0;
  bit          send_steady  = 1'b0;
  bit          sink_steady  = 1'b0;

  palette_fade_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Goal of one component: black while fading out, the target while fading in.
  function automatic logic [7:0] goal_of(int e, int c);
    return fading_in_q ? target_pal[e][c] : 8'h00;
  endfunction

  function automatic logic palette_settled();
    for (int e = 0; e < Entries; e++) begin
      for (int c = 0; c < 3; c++) begin
        if (shown_pal[e][c] != goal_of(e, c)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Ticks still needed until every component reaches its goal.
  function automatic int unsigned fade_distance();
    int unsigned most;
    int d;
    most = 0;
    for (int e = 0; e < Entries; e++) begin
      for (int c = 0; c < 3; c++) begin
        d = int'(shown_pal[e][c]) - int'(goal_of(e, c));
        if (d < 0) d = -d;
        if (d > most) most = d;
      end
    end
    return most;
  endfunction

  // Applies one item to the predicted palettes and returns its result.
  function automatic pfe_out_t fade_step(pfe_in_t it);
    pfe_out_t res;
    int idx;
    res = '0;
    idx = int'(it.entry_index);
    case (it.kind)
      KindWrite: begin
        if (idx < Entries) begin
          target_pal[idx][0] = it.red_in;
          target_pal[idx][1] = it.green_in;
          target_pal[idx][2] = it.blue_in;
        end
      end
      KindFadeOut: begin
        for (int e = 0; e < Entries; e++) begin
          for (int c = 0; c < 3; c++) shown_pal[e][c] = target_pal[e][c];
        end
        fading_in_q = 1'b0;
      end
      KindFadeIn: begin
        for (int e = 0; e < Entries; e++) begin
          for (int c = 0; c < 3; c++) shown_pal[e][c] = 8'h00;
        end
        fading_in_q = 1'b1;
      end
      KindTick: begin
        for (int e = 0; e < Entries; e++) begin
          for (int c = 0; c < 3; c++) begin
            if (shown_pal[e][c] < goal_of(e, c)) begin
              shown_pal[e][c] = shown_pal[e][c] + 8'd1;
            end else if (shown_pal[e][c] > goal_of(e, c)) begin
              shown_pal[e][c] = shown_pal[e][c] - 8'd1;
            end
          end
        end
      end
      KindRead: begin
        if (idx < Entries) begin
          res.red_out   = shown_pal[idx][0];
          res.green_out = shown_pal[idx][1];
          res.blue_out  = shown_pal[idx][2];
        end
      end
      default: begin
      end
    endcase
    res.fade_done = palette_settled();
    return res;
  endfunction

  // Mostly low levels so that fades finish in a few ticks, now and then any.
  function automatic logic [7:0] pick_level();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, LowLevel));
  endfunction

  // Prefers entries that were written lately, so reads see nonzero colors.
  function automatic logic [7:0] pick_entry();
    if (touched.size() > 0 && $urandom_range(0, 2) != 0) begin
      return touched[$urandom_range(0, touched.size() - 1)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_row(pfe_in_t item, bit typed, pfe_out_t result);
    dir_row_t row;
    row.item   = item;
    row.typed  = typed;
    row.result = result;
    dir_rows.push_back(row);
  endfunction

  // Offers one item after a random gap and records its expected result once
  // the transfer has taken place.
  task automatic send_item(pfe_in_t it, bit typed, pfe_out_t typed_res);
    int unsigned gap;
    pfe_out_t predicted;
    if (items_sent % 64 == 0) send_steady = ($urandom_range(0, 3) == 0);
    gap = send_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = fade_step(it);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    case (it.kind)
      KindWrite:   writes_sent++;
      KindFadeOut: fades_sent++;
      KindFadeIn:  fades_sent++;
      KindTick: begin
        ticks_sent++;
        if (predicted.fade_done) settled_seen++;
      end
      KindRead:    reads_sent++;
      default:     spare_sent++;
    endcase
    if (it.kind <= KindRead) items_real++;
  endtask

  task automatic issue(logic [2:0] kind, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                       logic [7:0] b);
    pfe_in_t it;
    it.kind        = kind;
    it.entry_index = idx;
    it.red_in      = r;
    it.green_in    = g;
    it.blue_in     = b;
    send_item(it, 1'b0, BlankDone);
    if (kind == KindWrite) begin
      touched.push_back(idx);
      if (touched.size() > 16) void'(touched.pop_front());
    end
  endtask

  task automatic issue_noise();
    issue(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Result side: random stalls, with stretches of steady acceptance.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 48 == 0) sink_steady = ($urandom_range(0, 3) == 0);
      stall = sink_steady ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Compares every result transfer with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    pfe_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (reported < MaxReported) begin
          reported++;
          $display("%0t: result with nothing expected: %p", $realtime, out_data_o);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.red_out !== want.red_out || out_data_o.green_out !== want.green_out ||
            out_data_o.blue_out !== want.blue_out ||
            out_data_o.fade_done !== want.fade_done) begin
          mismatches++;
          if (reported < MaxReported) begin
            reported++;
            $display("%0t: mismatch, expected rgb %02h %02h %02h done %0b, got %02h %02h %02h done %0b",
                     $realtime, want.red_out, want.green_out, want.blue_out, want.fade_done,
                     out_data_o.red_out, out_data_o.green_out, out_data_o.blue_out,
                     out_data_o.fade_done);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned need;
    int unsigned ticks;
    int unsigned fixed;
    int unsigned start;
    int unsigned long_runs;
    int idx;

    for (int e = 0; e < Entries; e++) begin
      for (int c = 0; c < 3; c++) begin
        target_pal[e][c] = 8'h00;
        shown_pal[e][c]  = 8'h00;
      end
    end
    fading_in_q = 1'b0;
    long_runs   = 2;

    // Directed table: reset state, unused kinds, fades at both extremes and a
    // target rewritten while fading in.
    add_row('{KindRead, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, BlankDone);
    add_row('{KindRead, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, BlankDone);
    add_row('{KindTick, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, BlankDone);
    add_row('{KindSpareHigh, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, BlankDone);
    add_row('{KindSpareLow, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b1, BlankDone);
    add_row('{KindWrite, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, BlankDone);
    add_row('{KindWrite, 8'h00, 8'h01, 8'h02, 8'h03}, 1'b1, BlankDone);
    add_row('{KindFadeOut, 8'hAA, 8'h00, 8'h00, 8'h00}, 1'b1, BlankBusy);
    add_row('{KindRead, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b0});
    add_row('{KindTick, 8'h55, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindRead, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindRead, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindFadeIn, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1, BlankBusy);
    add_row('{KindTick, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindRead, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindWrite, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindTick, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindRead, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindWrite, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindTick, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindRead, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0, BlankDone);
    add_row('{KindSpareMid, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, BlankBusy);
    add_row('{KindFadeOut, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, BlankDone);
    add_row('{KindWrite, 8'hAA, 8'hAA, 8'h55, 8'h0F}, 1'b1, BlankDone);
    add_row('{KindFadeOut, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, BlankBusy);
    add_row('{KindRead, 8'hAA, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'hAA, 8'h55, 8'h0F, 1'b0});

    // Reset, then the block clears its memories before taking items.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

    // Random scenes: new targets, a fade start, ticks with reads and rewrites
    // mixed in, then a few reads of the outcome.
    while (items_real < ItemGoal) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) issue_noise();
      end

      // Pull bright targets back down now and then so most fades stay short.
      if ($urandom_range(0, 1) == 0) begin
        fixed = 0;
        start = $urandom_range(0, Entries - 1);
        for (int e = 0; e < Entries && fixed < 4; e++) begin
          idx = (start + e) % Entries;
          if (target_pal[idx][0] > LowLevel || target_pal[idx][1] > LowLevel ||
              target_pal[idx][2] > LowLevel) begin
            issue(KindWrite, 8'(idx), 8'($urandom_range(0, LowLevel)),
                  8'($urandom_range(0, LowLevel)), 8'($urandom_range(0, LowLevel)));
            fixed++;
          end
        end
      end

      repeat ($urandom_range(1, 6)) begin
        issue(KindWrite, 8'($urandom_range(0, 255)), pick_level(), pick_level(), pick_level());
      end

      case ($urandom_range(0, 7))
        0: begin
        end
        1, 2, 3, 4: issue(KindFadeIn, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        default:    issue(KindFadeOut, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase

      // Enough ticks to finish the fade, or a cut-short run.
      need  = fade_distance();
      ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, need)
                                          : need + $urandom_range(0, 2);
      if (ticks > ShortFade) begin
        if (long_runs > 0) long_runs--;
        else ticks = ShortFade;
      end

      for (int t = 0; t < ticks; t++) begin
        issue(KindTick, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) issue(KindRead, pick_entry(), 8'h00, 8'h00, 8'h00);
        if ($urandom_range(0, 9) == 0) begin
          issue(KindWrite, pick_entry(), pick_level(), pick_level(), pick_level());
        end
        if ($urandom_range(0, 19) == 0) issue_noise();
      end

      repeat ($urandom_range(1, 3)) begin
        issue(KindRead, pick_entry(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Sent %0d items: %0d target writes, %0d fade starts, %0d ticks, %0d reads, %0d unused.",
             items_sent, writes_sent, fades_sent, ticks_sent, reads_sent, spare_sent);
    $display("%0d ticks left the palette settled; %0d result errors.", settled_seen, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #25ms;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/pfe_pkg.sv
rtl/pfe_step_unit.sv
rtl/palette_fade_engine.sv
rtl/pfe_checker.sv
tb/sv/palette_fade_engine_test.sv
